### hdl/utbs_pkg.sv
// Shared codes for the upper-triangular back-substitution solver.
// Opcode and status encodings; no dependencies.
package utbs_pkg;
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_SOLVE  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_PIVOT = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] q32_t;
endpackage

### hdl/utbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/upper_triangular_back_substitution_top.sv
// Upper-triangular back-substitution solver, signed Q16.16.
// Uses utbs_pkg and one utbs_ram instance for the matrix.
//
// Usage:
//  - Input channel (in_valid / in_stall): each word is a load of one matrix
//    entry, a load of one right-hand-side entry, or a solve command.
//    Loads are taken one per cycle while in_stall is low. Opcode 3 and
//    out-of-range loads are dropped.
//  - A solve walks rows n-1 down to 0. Per row: setup; per off-diagonal
//    term a RAM read, 32x32 multiply and saturating 64-bit subtract;
//    then a pivot check, restoring division (one quotient bit per cycle)
//    and a saturate/store step. A zero pivot skips the divider; the pivot
//    check stores a zero result instead. Then n result words, one per
//    cycle when out_stall is low.
//  - in_stall is high from solve acceptance until the last result word is
//    loaded into the single output register; a stalled word holds until
//    taken. The last word of a solve has out_last set.
//  - cfg_wr_en writes size_in_use (0 acts as 1, clamped to MAX_SIZE and 16);
//    write only while idle.
//  - Synchronous active-low reset returns to idle, clears the output valid
//    and sets size_in_use to 16. The stores are not cleared.
module upper_triangular_back_substitution_top
  import utbs_pkg::*;
#(
  parameter int MAX_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [4:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [3:0]        in_row_index,
  input  logic [3:0]        in_col_index,
  input  logic signed [31:0] in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_solution_index,
  output logic signed [31:0] out_solution_value,
  output logic [1:0]        out_status,
  output logic              out_last
);
  // effective store depth: index fields are 4 bits
  localparam int SD  = (MAX_SIZE < 16) ? MAX_SIZE : 16;
  localparam int IW  = (SD > 1) ? $clog2(SD) : 1;
  localparam int MD  = SD * SD;
  localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROW  = 4'd1;
  localparam logic [3:0] S_DIAG = 4'd2;
  localparam logic [3:0] S_MRD  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_DVS  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  function automatic logic [MAW-1:0] maddr(input logic [3:0] r, input logic [3:0] c);
    logic [9:0] a;
    a = {6'd0, r} * 10'(SD) + {6'd0, c};
    return a[MAW-1:0];
  endfunction

  logic [3:0]  st_r, st_nxt;
  logic [4:0]  size_r, size_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [3:0]  row_r, row_nxt;
  logic [4:0]  col_r, col_nxt;
  logic [3:0]  k_r, k_nxt;
  q32_t        acc_r, acc_nxt;
  q16_t        d_r, d_nxt;
  q16_t        x_r, x_nxt;
  q32_t        prod_r, prod_nxt;
  logic        ovf_r, ovf_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] ud_r, ud_nxt;
  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;

  q16_t        rhs_r  [SD];
  q16_t        sol_r  [SD];
  logic [1:0]  stat_r [SD];

  logic        sol_we;
  logic [3:0]  sol_idx;
  q16_t        sol_wdata;
  logic [1:0]  stat_wdata;

  logic        in_acc, out_load;
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_idx_r;
  q16_t        out_val_r;
  logic [1:0]  out_stat_r;
  logic        out_last_r;

  logic        ram_we;
  logic [MAW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_rdata;

  logic [4:0]  n_eff;
  logic [64:0] diff;
  logic [32:0] trial;
  logic [63:0] abs_acc;

  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // clamp the configured size
  always_comb begin
    n_eff = (size_r == 5'd0) ? 5'd1 : size_r;
    if (n_eff > 5'(SD)) begin
      n_eff = 5'(SD);
    end
  end

  // matrix store writes come only from loads
  assign ram_we    = in_acc && (in_opcode == OP_LOAD_A) &&
                     ({1'b0, in_row_index} < 5'(SD)) && ({1'b0, in_col_index} < 5'(SD));
  assign ram_waddr = maddr(in_row_index, in_col_index);
  assign ram_raddr = (st_r == S_ROW) ? maddr(row_r, row_r) : maddr(row_r, col_r[3:0]);

  utbs_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign diff    = {acc_r[63], acc_r} - {prod_r[63], prod_r};
  assign trial   = {rem_r, q_r[63]};
  assign abs_acc = acc_r[63] ? (64'd0 - acc_r) : acc_r;
  assign out_load = (st_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    st_nxt     = st_r;
    size_nxt   = size_r;
    n_nxt      = n_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    k_nxt      = k_r;
    acc_nxt    = acc_r;
    d_nxt      = d_r;
    x_nxt      = x_r;
    prod_nxt   = prod_r;
    ovf_nxt    = ovf_r;
    neg_nxt    = neg_r;
    ud_nxt     = ud_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    sol_we     = 1'b0;
    sol_idx    = row_r;
    sol_wdata  = '0;
    stat_wdata = ST_OK;

    if (cfg_wr_en) begin
      size_nxt = cfg_wr_data;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_acc && in_opcode == OP_SOLVE) begin
          n_nxt   = n_eff;
          row_nxt = 4'(n_eff - 5'd1);
          st_nxt  = S_ROW;
        end
      end
      S_ROW: begin
        acc_nxt = {{16{rhs_r[IW'(row_r)][31]}}, rhs_r[IW'(row_r)], 16'd0};
        col_nxt = {1'b0, row_r} + 5'd1;
        ovf_nxt = 1'b0;
        st_nxt  = S_DIAG;
      end
      S_DIAG: begin
        d_nxt  = ram_rdata;
        st_nxt = (col_r < n_r) ? S_MRD : S_DVS;
      end
      S_MRD: begin
        x_nxt  = sol_r[IW'(col_r)];
        st_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = q32_t'(q16_t'(ram_rdata)) * q32_t'(x_r);
        st_nxt   = S_ACC;
      end
      S_ACC: begin
        // saturating 64-bit subtract
        if (diff[64] != diff[63]) begin
          ovf_nxt = 1'b1;
          acc_nxt = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          acc_nxt = diff[63:0];
        end
        col_nxt = col_r + 5'd1;
        st_nxt  = ((col_r + 5'd1) < n_r) ? S_MRD : S_DVS;
      end
      S_DVS: begin
        if (d_r == '0) begin
          sol_we     = 1'b1;
          sol_wdata  = '0;
          stat_wdata = ST_ZERO_PIVOT;
          if (row_r == 4'd0) begin
            k_nxt  = 4'd0;
            st_nxt = S_OUT;
          end else begin
            row_nxt = row_r - 4'd1;
            st_nxt  = S_ROW;
          end
        end else begin
          neg_nxt = acc_r[63] ^ d_r[31];
          ud_nxt  = d_r[31] ? (32'd0 - d_r) : d_r;
          q_nxt   = abs_acc;
          rem_nxt = '0;
          cnt_nxt = 7'd64;
          st_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, ud_r}) begin
          rem_nxt = 32'(trial - {1'b0, ud_r});
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          q_nxt   = {q_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        sol_we = 1'b1;
        if (neg_r) begin
          if (q_r > 64'h8000_0000) begin
            sol_wdata  = 32'h8000_0000;
            stat_wdata = ST_OVERFLOW;
          end else begin
            sol_wdata  = 32'd0 - q_r[31:0];
            stat_wdata = ovf_r ? ST_OVERFLOW : ST_OK;
          end
        end else begin
          if (q_r > 64'h7FFF_FFFF) begin
            sol_wdata  = 32'h7FFF_FFFF;
            stat_wdata = ST_OVERFLOW;
          end else begin
            sol_wdata  = q_r[31:0];
            stat_wdata = ovf_r ? ST_OVERFLOW : ST_OK;
          end
        end
        if (row_r == 4'd0) begin
          k_nxt  = 4'd0;
          st_nxt = S_OUT;
        end else begin
          row_nxt = row_r - 4'd1;
          st_nxt  = S_ROW;
        end
      end
      S_OUT: begin
        if (out_load) begin
          k_nxt = k_r + 4'd1;
          if ({1'b0, k_r} == n_r - 5'd1) begin
            st_nxt = S_IDLE;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      size_r      <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    d_r    <= d_nxt;
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    ovf_r  <= ovf_nxt;
    neg_r  <= neg_nxt;
    ud_r   <= ud_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    if (in_acc && in_opcode == OP_LOAD_B && ({1'b0, in_row_index} < 5'(SD))) begin
      rhs_r[IW'(in_row_index)] <= in_value;
    end
    if (sol_we) begin
      sol_r[IW'(sol_idx)]  <= sol_wdata;
      stat_r[IW'(sol_idx)] <= stat_wdata;
    end
    if (out_load) begin
      out_idx_r  <= k_r;
      out_val_r  <= sol_r[IW'(k_r)];
      out_stat_r <= stat_r[IW'(k_r)];
      out_last_r <= ({1'b0, k_r} == n_r - 5'd1);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_solution_index = out_idx_r;
  assign out_solution_value = out_val_r;
  assign out_status         = out_stat_r;
  assign out_last           = out_last_r;

  // a solve command always starts the row walk
  a_solve_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == OP_SOLVE) |=> (st_r == S_ROW))
    else $error("solve did not start row walk");

  // loading the final word returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ({1'b0, k_r} == n_r - 5'd1)) |=> (st_r == S_IDLE && out_last))
    else $error("last word did not end the solve");

  // a zero-pivot word carries a zero value
  a_zero_pivot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ZERO_PIVOT) |-> (out_solution_value == '0))
    else $error("zero pivot with nonzero value");

  // divider runs exactly until its counter drains
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (cnt_r != 7'd0))
    else $error("divider counter underflow");
endmodule

### bench/testbench.sv
// Self-checking bench for upper_triangular_back_substitution_top.
// Depends on utbs_pkg and the solver RTL; predicts each solve in-bench.
module testbench;
  import utbs_pkg::*;

  localparam int LIMIT        = 5000000;  // hard stop in cycles
  localparam int DRAIN_CYCLES = 40;       // idle gap before a size write
  localparam int QUIET_LO     = 30000;    // window with no random idling
  localparam int QUIET_HI     = 60000;

  localparam logic [1:0] OP_UNUSED = 2'd3;  // not decoded by the block

  typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t  kind;
    logic [1:0] op;
    logic [3:0] row;
    logic [3:0] col;
    q16_t       value;
    logic [4:0] size;
  } act_t;

  typedef struct packed {
    logic [3:0] index;
    q16_t       value;
    logic [1:0] status;
    logic       last;
  } solution_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [3:0]  in_row_index = '0;
  logic [3:0]  in_col_index = '0;
  q16_t        in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_solution_index;
  q16_t        out_solution_value;
  logic [1:0]  out_status;
  logic        out_last;

  upper_triangular_back_substitution_top u_top (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_stall, .in_opcode, .in_row_index, .in_col_index, .in_value,
    .out_valid, .out_stall, .out_solution_index, .out_solution_value,
    .out_status, .out_last
  );

  always #6 clk = ~clk;

  // Mirror of the solver state
  q16_t       coef[16][16];
  q16_t       rhs[16];
  q16_t       xsol[16];
  logic [4:0] n_reg = 5'd16;

  act_t       pending_acts[$];
  solution_t  expected_solutions[$];

  int  cycle = 0;
  int  mismatches = 0;
  int  words_taken = 0;
  int  solves_taken = 0;
  int  results_seen = 0;
  int  drain_wait = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  took = 0;      // input word accepted at the last rising edge
  bit  quiet;

  assign quiet = (cycle >= QUIET_LO) && (cycle < QUIET_HI);

  // Back substitution, last row first; Q32.32 accumulator, Q16.16 result.
  task automatic solve_system();
    int n;
    logic [1:0] st[16];
    longint acc, prod;
    logic signed [64:0] diff;
    logic [63:0] ua, ud, quo;
    logic neg, ovf;
    q16_t d;
    solution_t s;
    n = (n_reg == 0) ? 1 : (n_reg > 16) ? 16 : n_reg;
    for (int row = n - 1; row >= 0; row--) begin
      ovf = 1'b0;
      acc = longint'(rhs[row]) * 64'sd65536;
      d = coef[row][row];
      for (int col = row + 1; col < n; col++) begin
        prod = longint'(coef[row][col]) * longint'(xsol[col]);
        diff = {acc[63], acc} - {prod[63], prod};
        if (diff[64] != diff[63]) begin
          ovf = 1'b1;
          acc = diff[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        end else begin
          acc = diff[63:0];
        end
      end
      if (d == 0) begin
        xsol[row] = '0;
        st[row] = ST_ZERO_PIVOT;
      end else begin
        neg = (acc < 0) != (d < 0);
        ua = (acc < 0) ? 64'd0 - acc : acc;
        ud = (d < 0) ? 64'd0 - longint'(d) : longint'(d);
        quo = ua / ud;
        if (neg) begin
          if (quo > 64'h8000_0000) begin
            ovf = 1'b1;
            xsol[row] = 32'h8000_0000;
          end else begin
            xsol[row] = 32'd0 - quo[31:0];
          end
        end else if (quo > 64'h7fff_ffff) begin
          ovf = 1'b1;
          xsol[row] = 32'h7fff_ffff;
        end else begin
          xsol[row] = quo[31:0];
        end
        st[row] = ovf ? ST_OVERFLOW : ST_OK;
      end
    end
    for (int k = 0; k < n; k++) begin
      s.index = 4'(k);
      s.value = xsol[k];
      s.status = st[k];
      s.last = (k == n - 1);
      expected_solutions.push_back(s);
    end
  endtask

  task automatic report_mismatch(string what, solution_t exp_s, solution_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0d] %s: exp idx=%0d val=%h st=%0d last=%0b | got idx=%0d val=%h st=%0d last=%0b",
               cycle, what, exp_s.index, exp_s.value, exp_s.status, exp_s.last,
               got.index, got.value, got.status, got.last);
  endtask

  // Rising edge: track accepted words, config writes and results
  always @(posedge clk) begin
    solution_t got, exp_s;
    cycle <= cycle + 1;
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      took <= in_valid && !in_stall;
      if (cfg_wr_en) n_reg = cfg_wr_data;
      if (in_valid && !in_stall) begin
        words_taken++;
        case (in_opcode)
          OP_LOAD_A: coef[in_row_index][in_col_index] = in_value;
          OP_LOAD_B: rhs[in_row_index] = in_value;
          OP_SOLVE: begin
            solves_taken++;
            solve_system();
          end
          default: ;  // unused opcode is dropped
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        got.index = out_solution_index;
        got.value = out_solution_value;
        got.status = out_status;
        got.last = out_last;
        if (expected_solutions.size() == 0) begin
          exp_s = '0;
          report_mismatch("unexpected word", exp_s, got);
        end else begin
          exp_s = expected_solutions.pop_front();
          if (got !== exp_s) report_mismatch("mismatch", exp_s, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle >= LIMIT) begin
      $display("Timeout after %0d cycles", cycle);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sender: drives at the falling edge from the pending queue
  always @(negedge clk) begin
    logic v_n, c_en;
    logic [4:0] c_d;
    act_t a;
    if (rst_n) begin
      v_n = in_valid && !took;
      c_en = 1'b0;
      c_d = cfg_wr_data;
      if (!v_n && pending_acts.size() > 0) begin
        a = pending_acts[0];
        case (a.kind)
          ACT_WORD: begin
            if (quiet || $urandom_range(99) >= 6) begin
              void'(pending_acts.pop_front());
              in_opcode <= a.op;
              in_row_index <= a.row;
              in_col_index <= a.col;
              in_value <= a.value;
              v_n = 1'b1;
            end
          end
          ACT_CFG: begin
            void'(pending_acts.pop_front());
            c_en = 1'b1;
            c_d = a.size;
          end
          default: begin
            // pause until all results are back, then let the block settle
            if (expected_solutions.size() != 0) begin
              drain_wait <= 0;
            end else if (drain_wait >= DRAIN_CYCLES) begin
              void'(pending_acts.pop_front());
              drain_wait <= 0;
            end else begin
              drain_wait <= drain_wait + 1;
            end
          end
        endcase
      end
      in_valid <= v_n;
      cfg_wr_en <= c_en;
      cfg_wr_data <= c_d;
    end
  end

  // Receiver: random stalls plus one long hold-off that backs up the input
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && solves_taken >= 8 && in_valid && in_stall) begin
        // a word is waiting on a busy block: hold off long enough to fill it
        hold_done <= 1'b1;
        hold_left <= 2000;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 6);
      end
    end
  end

  function automatic q16_t rand_q16();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  function automatic q16_t rand_pivot();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return $urandom_range(3);
      2: return $urandom;
      default: return (($urandom_range(1)) ? 32'sd65536 : -32'sd65536)
                      + $signed($urandom_range(32767)) - 32'sd16384;
    endcase
  endfunction

  task automatic add_word(logic [1:0] op, logic [3:0] r, logic [3:0] c, q16_t v);
    act_t a;
    a = '{kind: ACT_WORD, op: op, row: r, col: c, value: v, size: '0};
    pending_acts.push_back(a);
  endtask

  task automatic add_size(logic [4:0] sz);
    act_t a;
    a = '{kind: ACT_DRAIN, op: '0, row: '0, col: '0, value: '0, size: '0};
    pending_acts.push_back(a);
    a.kind = ACT_CFG;
    a.size = sz;
    pending_acts.push_back(a);
  endtask

  initial begin
    int n, r, c, budget;
    // Fill the whole upper triangle and every rhs entry first, so no
    // solve ever reads an entry that was never written.
    for (r = 0; r < 16; r++) begin
      add_word(OP_LOAD_B, 4'(r), 4'($urandom), rand_q16());
      for (c = r; c < 16; c++)
        add_word(OP_LOAD_A, 4'(r), 4'(c),
                 (r == c) ? 32'sd65536 : $signed($urandom_range(8191)) - 32'sd4096);
    end
    add_word(OP_SOLVE, 4'hf, 4'hf, 32'h0);
    // Directed corners: zero pivot, tiny pivot, extreme rhs and pivot
    add_word(OP_LOAD_A, 4'd15, 4'd15, 32'h0);
    add_word(OP_SOLVE, 4'd0, 4'd0, 32'hffff_ffff);
    add_word(OP_LOAD_A, 4'd15, 4'd15, 32'sd1);
    add_word(OP_LOAD_B, 4'd15, 4'd0, 32'h7fff_ffff);
    add_word(OP_SOLVE, 4'd0, 4'd0, 32'h0);
    add_word(OP_LOAD_A, 4'd15, 4'd15, 32'h8000_0000);
    add_word(OP_LOAD_B, 4'd15, 4'd0, 32'h8000_0000);
    add_word(OP_SOLVE, 4'd0, 4'd0, 32'h0);
    add_word(OP_UNUSED, 4'hf, 4'hf, 32'hffff_ffff);
    add_word(OP_LOAD_A, 4'd0, 4'd0, 32'h7fff_ffff);
    add_size(5'd1);
    add_word(OP_SOLVE, 4'd0, 4'd0, 32'h0);
    add_size(5'd0);                              // acts as one unknown
    add_word(OP_LOAD_B, 4'd0, 4'd0, 32'h8000_0000);
    add_word(OP_SOLVE, 4'd0, 4'd0, 32'h0);
    add_size(5'd31);                             // clamps to sixteen
    add_word(OP_SOLVE, 4'd0, 4'd0, 32'h0);

    // Random phases, each with its own size
    for (int ph = 0; ph < 12; ph++) begin
      n = (ph % 4 == 3) ? 16 : $urandom_range(1, 8);
      add_size(5'(n));
      budget = 28;
      while (budget > 0) begin
        if ($urandom_range(99) < 80) begin
          // well-formed: refresh some used entries, then solve
          for (int k = $urandom_range(1, 2 * n); k > 0; k--) begin
            r = $urandom_range(n - 1);
            if ($urandom_range(3) == 0) begin
              add_word(OP_LOAD_B, 4'(r), 4'($urandom), rand_q16());
            end else begin
              c = $urandom_range(r, n - 1);
              add_word(OP_LOAD_A, 4'(r), 4'(c), (r == c) ? rand_pivot() : rand_q16());
            end
            budget--;
          end
          add_word(OP_SOLVE, 4'($urandom), 4'($urandom), $urandom);
        end else begin
          // noise: dropped opcode, stray loads, bare solve
          case ($urandom_range(2))
            0: add_word(OP_UNUSED, 4'($urandom), 4'($urandom), $urandom);
            1: add_word(OP_LOAD_A, 4'($urandom), 4'($urandom), rand_q16());
            default: add_word(OP_SOLVE, 4'($urandom), 4'($urandom), $urandom);
          endcase
        end
        budget--;
      end
    end
    add_size(5'd16);
    add_word(OP_SOLVE, 4'd0, 4'd0, 32'h0);

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_acts.size() != 0 || in_valid) @(posedge clk);
    while (expected_solutions.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d input words, %0d solves, %0d result words in %0d cycles",
             words_taken, solves_taken, results_seen, cycle);
    $display("Sizes 0, 1, 16, 31 and random; pivots zero, tiny and extreme; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_solutions.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
